// ===== design/assert_macros.svh =====
// Assertion macros shared by the size-class cache design files.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SCB_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: name");

// Implication whose consequent must hold in the cycle after the antecedent.
`define SCB_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: name");

`endif

// ===== design/scb_pkg.sv =====
// Package for the size-class buffer cache: sizes, status codes, state and structs.
// Depends on nothing; imported by every module of the block.
package scb_pkg;

   localparam int MIN_SHIFT   = 6;
   localparam int MAX_SHIFT   = 26;
   localparam int STACK_DEPTH = 8;
   localparam int HANDLE_BITS = 32;

   localparam int NUM_CLASSES     = MAX_SHIFT - MIN_SHIFT + 1;
   localparam int CLASS_BITS      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int COUNT_BITS      = $clog2(STACK_DEPTH + 1);
   localparam int STACK_ENTRIES   = NUM_CLASSES * STACK_DEPTH;
   localparam int STACK_ADDR_BITS = $clog2(STACK_ENTRIES);
   localparam int LIMIT_BITS      = 4;
   localparam int LIMIT_RESET     = 8;

   typedef enum logic [2:0] {
      ST_HIT          = 3'd0,
      ST_MISS         = 3'd1,
      ST_BYPASS_ALLOC = 3'd2,
      ST_NULL         = 3'd3,
      ST_CACHED       = 3'd4,
      ST_FULL         = 3'd5,
      ST_BYPASS_FREE  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_RESP
   } state_type;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Decoded size class of one request size.
   typedef struct packed {
      logic                  nonzero;
      logic                  in_range;
      logic [CLASS_BITS-1:0] cls;
      logic [31:0]           csize;
   } class_info_type;

   typedef struct packed {
      logic                  en;
      logic [CLASS_BITS-1:0] addr;
      logic [COUNT_BITS-1:0] data;
   } count_wr_type;

   typedef struct packed {
      logic                       en;
      logic [STACK_ADDR_BITS-1:0] addr;
      logic [HANDLE_BITS-1:0]     data;
   } stack_wr_type;

endpackage

// ===== design/size_class_buffer_cache_unit.sv =====
// Top level of the size-class buffer cache: sequencer, statistics and memories.
// Depends on scb_pkg, scb_class_dec, scb_count_mem, scb_stack_ram, assert_macros.svh.
//
//   channel   ports                                    handshake
//   request   req_cmd, req_bytes, req_buf_handle       start high, busy low
//   response  rsp_status ... rsp_allocated_bytes       rsp_valid, one cycle
//   config    csr_wdata (per_class_limit)              csr_we
//
// A request is accepted at one edge, spends the next cycle in lookup and shows
// its response strobe in the cycle after that. A new request may be accepted in
// the cycle its predecessor's response is shown, but not while it is in lookup.
// Acceptance registers the count memory read; on a hit, lookup issues the stack
// memory read, whose register feeds the popped handle to the response.
// Reset is synchronous; it empties every class through the count valid bits
// at once, so no clearing pass is needed. The response cannot be stalled.
`include "assert_macros.svh"
module size_class_buffer_cache_unit
   import scb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_cmd,
   input  logic [31:0]           req_bytes,
   input  logic [31:0]           req_buf_handle,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_status,
   output logic [31:0]           rsp_out_handle,
   output logic [31:0]           rsp_alloc_bytes,
   output logic [31:0]           rsp_hit_total,
   output logic [31:0]           rsp_miss_total,
   output logic [31:0]           rsp_cached_bytes,
   output logic [47:0]           rsp_allocated_bytes,
   input  logic                  csr_we,
   input  logic [LIMIT_BITS-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic accept;

   // The request is held from acceptance through its response.
   logic           cmd_ff;
   logic [31:0]    bytes_ff;
   logic [31:0]    handle_ff;
   class_info_type info_ff;
   class_info_type info_dec;

   logic [LIMIT_BITS-1:0] limit_ff;
   logic [COUNT_BITS-1:0] limit_eff;

   logic [COUNT_BITS-1:0]      count_rd;
   count_wr_type               count_wr;
   stack_wr_type               stack_wr;
   logic                       stack_rd_en;
   logic [STACK_ADDR_BITS-1:0] stack_rd_addr;
   logic [STACK_ADDR_BITS-1:0] stack_base;
   logic [HANDLE_BITS-1:0]     stack_rd;

   status_type status_ff, status_in;
   logic [31:0] alloc_ff, alloc_in;
   logic [31:0] hit_ff, hit_in;
   logic [31:0] miss_ff, miss_in;
   logic [31:0] held_ff, held_in;
   logic [47:0] fresh_ff, fresh_in;

   assign accept = start && !busy;

   scb_class_dec u_dec (
      .bytes (req_bytes),
      .info  (info_dec)
   );

   // The count of the request's class is read as the request is accepted.
   scb_count_mem u_count (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (info_dec.cls),
      .wr      (count_wr),
      .rd_data (count_rd)
   );

   scb_stack_ram u_stack (
      .clock   (clock),
      .wr      (stack_wr),
      .rd_en   (stack_rd_en),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         bytes_ff  <= req_bytes;
         handle_ff <= req_buf_handle;
         info_ff   <= info_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_BITS'(LIMIT_RESET);
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // A limit above the stack depth saturates to the depth.
   assign limit_eff = (32'(limit_ff) > STACK_DEPTH) ? COUNT_BITS'(STACK_DEPTH)
                                                    : COUNT_BITS'(limit_ff);

   assign stack_base = STACK_ADDR_BITS'(32'(info_ff.cls) * STACK_DEPTH);

   // Decide the outcome from the class count, and issue the memory updates.
   always_comb begin
      status_in     = ST_NULL;
      alloc_in      = 32'd0;
      hit_in        = hit_ff;
      miss_in       = miss_ff;
      held_in       = held_ff;
      fresh_in      = fresh_ff;
      count_wr      = '0;
      stack_wr      = '0;
      stack_rd_en   = 1'b0;
      stack_rd_addr = stack_base + STACK_ADDR_BITS'(count_rd - COUNT_BITS'(1));
      if (state_ff == S_LOOKUP) begin
         if (cmd_ff == CMD_ALLOC) begin
            priority if (!info_ff.nonzero) begin
               status_in = ST_NULL;
            end else if (!info_ff.in_range) begin
               status_in = ST_BYPASS_ALLOC;
               alloc_in  = bytes_ff;
               miss_in   = miss_ff + 32'd1;
               fresh_in  = fresh_ff + 48'(bytes_ff);
            end else if (count_rd != '0) begin
               // Pop: the top entry sits one below the count.
               status_in     = ST_HIT;
               hit_in        = hit_ff + 32'd1;
               held_in       = held_ff - info_ff.csize;
               stack_rd_en   = 1'b1;
               count_wr.en   = 1'b1;
               count_wr.addr = info_ff.cls;
               count_wr.data = count_rd - COUNT_BITS'(1);
            end else begin
               status_in = ST_MISS;
               alloc_in  = info_ff.csize;
               miss_in   = miss_ff + 32'd1;
               fresh_in  = fresh_ff + 48'(info_ff.csize);
            end
         end else begin
            priority if (handle_ff == 32'd0) begin
               status_in = ST_NULL;
            end else if (!info_ff.in_range) begin
               status_in = ST_BYPASS_FREE;
            end else if (count_rd >= limit_eff) begin
               status_in = ST_FULL;
            end else begin
               // Push at the slot the count points to.
               status_in     = ST_CACHED;
               held_in       = held_ff + info_ff.csize;
               stack_wr.en   = 1'b1;
               stack_wr.addr = stack_base + STACK_ADDR_BITS'(count_rd);
               stack_wr.data = HANDLE_BITS'(handle_ff);
               count_wr.en   = 1'b1;
               count_wr.addr = info_ff.cls;
               count_wr.data = count_rd + COUNT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_LOOKUP) begin
         status_ff <= status_in;
         alloc_ff  <= alloc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= '0;
         miss_ff  <= '0;
         held_ff  <= '0;
         fresh_ff <= '0;
      end else begin
         hit_ff   <= hit_in;
         miss_ff  <= miss_in;
         held_ff  <= held_in;
         fresh_ff <= fresh_in;
      end
   end

   // Sequencer: lookup, then response; the response cycle can accept again.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      unique case (state_ff)
         S_IDLE:   state_in = start ? S_LOOKUP : S_IDLE;
         S_LOOKUP: state_in = S_RESP;
         S_RESP:   state_in = start ? S_LOOKUP : S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      busy      = (state_ff == S_LOOKUP);
      rsp_valid = (state_ff == S_RESP);
   end

   // The popped handle comes straight from the stack read register.
   assign rsp_status          = status_ff;
   assign rsp_out_handle      = (status_ff == ST_HIT) ? 32'(stack_rd) : 32'd0;
   assign rsp_alloc_bytes     = alloc_ff;
   assign rsp_hit_total       = hit_ff;
   assign rsp_miss_total      = miss_ff;
   assign rsp_cached_bytes    = held_ff;
   assign rsp_allocated_bytes = fresh_ff;

   `SCB_ASSERT_NEXT(a_accept_then_busy, clock, reset, start && !busy, busy)
   `SCB_ASSERT_NEXT(a_lookup_then_resp, clock, reset, busy, rsp_valid)
   `SCB_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)

endmodule

// ===== design/scb_class_dec.sv =====
// Size-class decoder: rounds a byte count up to its power-of-two class.
// Depends on scb_pkg.
module scb_class_dec
   import scb_pkg::*;
(
   input  logic [31:0]    bytes,
   output class_info_type info
);

   logic [31:0] size_m1;
   logic [5:0]  width;
   logic [5:0]  shift;

   assign size_m1 = bytes - 32'd1;

   // Number of significant bits of size minus one is the ceiling log2.
   always_comb begin
      width = 6'd0;
      for (int i = 0; i < MAX_SHIFT; i++) begin
         if (size_m1[i]) begin
            width = 6'(i + 1);
         end
      end
   end

   always_comb begin
      info.nonzero  = (bytes != 32'd0);
      info.in_range = info.nonzero && (size_m1[31:MAX_SHIFT] == '0);
      shift         = (width < 6'(MIN_SHIFT)) ? 6'(MIN_SHIFT) : width;
      info.cls      = info.in_range ? CLASS_BITS'(shift - 6'(MIN_SHIFT)) : '0;
      info.csize    = 32'd1 << shift[4:0];
   end

endmodule

// ===== design/scb_count_mem.sv =====
// Per-class fill count memory with one valid bit per class, cleared at reset.
// Depends on scb_pkg.
module scb_count_mem
   import scb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [CLASS_BITS-1:0] rd_addr,
   input  count_wr_type          wr,
   output logic [COUNT_BITS-1:0] rd_data
);

   logic [COUNT_BITS-1:0]  mem [NUM_CLASSES];
   logic [NUM_CLASSES-1:0] valid_ff;
   logic [COUNT_BITS-1:0]  data_ff;
   logic                   hit_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         hit_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // A class never written reads as an empty stack.
   assign rd_data = hit_valid_ff ? data_ff : '0;

endmodule

// ===== design/scb_stack_ram.sv =====
// Handle storage for all class stacks, one row of slots per class.
// Depends on scb_pkg.
module scb_stack_ram
   import scb_pkg::*;
(
   input  logic                       clock,
   input  stack_wr_type               wr,
   input  logic                       rd_en,
   input  logic [STACK_ADDR_BITS-1:0] rd_addr,
   output logic [HANDLE_BITS-1:0]     rd_data
);

   logic [HANDLE_BITS-1:0] mem [STACK_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
